// File: rtl/core/mt_pkg.sv
// MT19937 generator package: table geometry, recurrence and tempering constants,
// and the command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mt_pkg;

  localparam int unsigned StateWords  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned AddrW       = $clog2(StateWords);
  localparam int unsigned PosW        = 10;

  localparam logic [AddrW-1:0] LastAddr   = AddrW'(StateWords - 1);
  localparam logic [AddrW-1:0] FarFirst   = AddrW'(TwistOffset);
  localparam logic [PosW-1:0]  PosFull    = PosW'(StateWords);
  localparam logic [PosW-1:0]  PosNever   = PosW'(StateWords + 1);

  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] SeedMult    = 32'd1812433253;
  localparam logic [31:0] TwistXor    = 32'h9908b0df;
  localparam logic [31:0] TemperB     = 32'h9d2c5680;
  localparam logic [31:0] TemperC     = 32'hefc60000;

  localparam logic KindSeed = 1'b0;
  localparam logic KindDraw = 1'b1;

  typedef struct packed {
    logic seed_start;  // write word 0 and load the recurrence register
    logic seed_def;    // seed source is the default seed
    logic seed_step;   // write one word of the seed recurrence
    logic tw_prime;    // issue the first twist reads
    logic tw_step;     // write one twisted word, issue the next reads
    logic load_out;    // temper the fetched word into the output register
  } mt_cmd_t;

  typedef struct packed {
    logic never_seeded;
    logic exhausted;
    logic idx_last;
  } mt_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mersenne_twister_prng.sv
// MT19937 generator top level: controller plus datapath with a 624-word table.
// Depends on mt_pkg, mt_ctrl and mt_dp.
// Draw: each item comes from the table through the registered memory read.
// A draw that finds the table exhausted first twists it: one word twisted per cycle.
// Seed: fills the table, one recurrence step (multiply and add) per cycle.
// Reset clears control and sets the position to never seeded; no table sweep.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_prng (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] seed_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      random_word_o
);
  import mt_pkg::*;

  mt_cmd_t  cmd;
  mt_stat_t stat;

  mt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_value_i  (seed_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .random_word_o (random_word_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/mt_ctrl.sv
// MT19937 controller: one-hot sequencer over seed fill, table twist and draw.
// Depends on mt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             kind_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire mt_pkg::mt_stat_t stat_i,
  output mt_pkg::mt_cmd_t       cmd_o
);
  import mt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEED  = 5'b00010,
    S_TWRD  = 5'b00100,
    S_TWIST = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KindSeed) begin
            cmd_o.seed_start = 1'b1;
            pend_d           = 1'b0;
            state_d          = S_SEED;
          end else if (stat_i.never_seeded) begin
            // draw before any seed: fill with the default seed, then twist
            cmd_o.seed_start = 1'b1;
            cmd_o.seed_def   = 1'b1;
            pend_d           = 1'b1;
            state_d          = S_SEED;
          end else if (stat_i.exhausted) begin
            state_d = S_TWRD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SEED: begin
        cmd_o.seed_step = 1'b1;
        if (stat_i.idx_last) begin
          state_d = pend_q ? S_TWRD : S_IDLE;
          pend_d  = 1'b0;
        end
      end
      S_TWRD: begin
        cmd_o.tw_prime = 1'b1;
        state_d        = S_TWIST;
      end
      S_TWIST: begin
        cmd_o.tw_step = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mt_dp.sv
// MT19937 datapath: state table memory, position, seed recurrence, twist and tempering.
// Depends on mt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mt_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      seed_value_i,
  input  wire mt_pkg::mt_cmd_t  cmd_i,
  output mt_pkg::mt_stat_t      stat_o,
  output logic [31:0]           random_word_o
);
  import mt_pkg::*;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] a);
    return (a == LastAddr) ? '0 : a + AddrW'(1);
  endfunction

  logic [31:0]      mem [StateWords];
  logic [31:0]      rd_a_q, rd_b_q;
  logic [AddrW-1:0] addr_a, addr_b;
  logic [AddrW-1:0] nxt_q, far_q;
  logic [AddrW-1:0] idx_q;
  logic [PosW-1:0]  pos_q;
  logic [31:0]      prev_q;
  logic             msb0_q, cur_msb_q;
  logic [31:0]      word_q;
  logic [31:0]      seed_src, seed_mix, seed_next;
  logic [31:0]      tw_y, tw_v;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      wdata;
  logic             exhausted;

  assign exhausted = (pos_q >= PosFull);
  assign stat_o.never_seeded = (pos_q == PosNever);
  assign stat_o.exhausted    = exhausted;
  assign stat_o.idx_last     = (idx_q == LastAddr);

  assign seed_src  = cmd_i.seed_def ? DefaultSeed : seed_value_i;
  assign seed_mix  = prev_q ^ (prev_q >> 30);
  assign seed_next = SeedMult * seed_mix + {{(32-AddrW){1'b0}}, idx_q};

  // word k keeps its top bit, word k+1 gives the rest
  assign tw_y = {cur_msb_q, rd_a_q[30:0]};
  assign tw_v = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? TwistXor : 32'h0);

  always_comb begin
    if (cmd_i.tw_prime) begin
      addr_a = AddrW'(1);
      addr_b = FarFirst;
    end else if (cmd_i.tw_step && (idx_q != LastAddr)) begin
      addr_a = nxt_q;
      addr_b = far_q;
    end else begin
      // fetch the word at the position; after the twist that is word 0
      addr_a = exhausted ? '0 : pos_q[AddrW-1:0];
      addr_b = '0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = seed_next;
    priority if (cmd_i.seed_start) begin
      we    = 1'b1;
      waddr = '0;
      wdata = seed_src;
    end else if (cmd_i.seed_step) begin
      we = 1'b1;
    end else if (cmd_i.tw_step) begin
      we    = 1'b1;
      wdata = tw_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_start) begin
      prev_q <= seed_src;
      idx_q  <= AddrW'(1);
    end else if (cmd_i.seed_step) begin
      prev_q <= seed_next;
      idx_q  <= idx_q + AddrW'(1);
    end else if (cmd_i.tw_prime) begin
      idx_q     <= '0;
      nxt_q     <= AddrW'(2);
      far_q     <= FarFirst + AddrW'(1);
      cur_msb_q <= msb0_q;
    end else if (cmd_i.tw_step) begin
      idx_q     <= idx_q + AddrW'(1);
      nxt_q     <= wrap_inc(nxt_q);
      far_q     <= wrap_inc(far_q);
      cur_msb_q <= rd_a_q[31];
    end
    if (we && (waddr == '0)) begin
      msb0_q <= wdata[31];
    end
    if (cmd_i.load_out) begin
      word_q <= temper(rd_a_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosNever;
    end else if (cmd_i.seed_step && (idx_q == LastAddr)) begin
      pos_q <= PosFull;
    end else if (cmd_i.tw_step && (idx_q == LastAddr)) begin
      pos_q <= '0;
    end else if (cmd_i.load_out) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  assign random_word_o = word_q;

endmodule

`default_nettype wire
